// ----- rtl/core/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the prime table sieve
// Sizes of the odd-only bit store and the prime table, transfer structs,
// status codes and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Elaboration-time integer square root.
  function automatic int isqrt(input int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  localparam int SIEVE_BITS  = 65536;
  localparam int MAX_PRIMES  = 4096;

  // Field widths of the transfers and the config register.
  localparam int CFG_W = 13;
  localparam int IDX_W = 12;
  localparam int VAL_W = 16;
  localparam int DBL_W = 17;

  // Odd-only bit store: entry k stands for the number 2k+1.
  localparam int BIT_DEPTH   = SIEVE_BITS / 2;
  localparam int BIT_AW      = $clog2(BIT_DEPTH);
  localparam int ROOT_END    = isqrt(SIEVE_BITS) + 1;
  localparam int I_W         = $clog2(ROOT_END + 2);
  localparam int M_W         = $clog2(SIEVE_BITS) + 2;
  localparam int SCAN_END    = (SIEVE_BITS > 65536) ? 65536 : SIEVE_BITS;
  localparam int SCAN_HALF   = SCAN_END / 2;

  // Prime table.
  localparam int TBL_AW = $clog2(MAX_PRIMES);
  localparam int CNT_W  = $clog2(MAX_PRIMES + 1);
  localparam int CMP_W0 = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CMP_W  = (CMP_W0 > IDX_W) ? CMP_W0 : IDX_W;

  localparam logic [CFG_W-1:0] PRIME_COUNT_RST = CFG_W'(4096);
  localparam logic [VAL_W-1:0] FIRST_PRIME     = VAL_W'(2);

  typedef enum logic {
    OP_BUILD = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_BUILD_DONE = 2'd0,
    ST_READ_OK    = 2'd1,
    ST_BEYOND     = 2'd2,
    ST_NOT_BUILT  = 2'd3
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] entry_index;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] prime_value;
    logic [DBL_W-1:0] prime_doubled;
    status_t          status;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SV_RD,
    S_SV_CHK,
    S_MARK,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd_accept;
    logic build_init;
    logic clear_step;
    logic sv_read;
    logic sv_next;
    logic mark_load;
    logic mark_step;
    logic scan_init;
    logic scan_run;
    logic build_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic i_done;
    logic bit_marked;
    logic mark_end;
    logic scan_done;
  } dp_stat_t;

endpackage

// ----- rtl/core/pts_ram.sv -----
// ----------------------------------------------------------------------------
// pts_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pts_ctrl: build sequencer
// Steps clear, sieve and scan phases of a build; passes reads straight on.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pts_pkg::op_t       op,
  input  pts_pkg::dp_stat_t  stat,
  output pts_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import pts_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && op == OP_BUILD) state_next = S_CLEAR;
      end
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_SV_RD;
      end
      S_SV_RD: begin
        state_next = stat.i_done ? S_SCAN : S_SV_CHK;
      end
      S_SV_CHK: begin
        state_next = stat.bit_marked ? S_SV_RD : S_MARK;
      end
      S_MARK: begin
        if (stat.mark_end) state_next = S_SV_RD;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.build_init = start && op == OP_BUILD;
        cmd.rd_accept  = start && op == OP_READ;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      S_SV_RD: begin
        cmd.scan_init = stat.i_done;
        cmd.sv_read   = !stat.i_done;
      end
      S_SV_CHK: begin
        cmd.sv_next   = stat.bit_marked;
        cmd.mark_load = !stat.bit_marked;
      end
      S_MARK: begin
        cmd.sv_next   = stat.mark_end;
        cmd.mark_step = !stat.mark_end;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      S_DONE: begin
        cmd.build_done = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/pts_datapath.sv -----
// ----------------------------------------------------------------------------
// pts_datapath: counters, bit store, prime table and result stage
// Executes the sequencer's commands and registers every result.
// ----------------------------------------------------------------------------
module pts_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  pts_pkg::item_t            item,
  input  logic                      cfg_we,
  input  logic [pts_pkg::CFG_W-1:0] cfg_wdata,
  input  pts_pkg::ctrl_cmd_t        cmd,
  output pts_pkg::dp_stat_t         stat,
  output logic                      done,
  output pts_pkg::result_t          result
);
  import pts_pkg::*;

  // config and table state
  logic [CFG_W-1:0] prime_count;
  logic             table_built;
  logic [CNT_W-1:0] built_count;

  // build counters
  logic [CNT_W-1:0]  want;
  logic [BIT_AW-1:0] clr_addr;
  logic [I_W-1:0]    i;
  logic [M_W-1:0]    m;
  logic [BIT_AW:0]   sc_addr;
  logic              sc_vld;
  logic [VAL_W-1:0]  sc_val;
  logic [CNT_W-1:0]  stored;

  // read pipeline
  logic    r1_vld;
  status_t r1_status;
  status_t rd_status;

  // memories
  logic              bit_we;
  logic [BIT_AW-1:0] bit_waddr;
  logic              bit_wdata;
  logic [BIT_AW-1:0] bit_raddr;
  logic              bit_rdata;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [VAL_W-1:0]  tbl_wdata;
  logic [VAL_W-1:0]  tbl_rdata;

  logic             scan_issue;
  logic             scan_wr;
  logic             scan_end;
  logic             want_met;
  logic [CNT_W-1:0] want_clamped;
  logic [CMP_W-1:0] idx_ext;

  // count request, zero means one, capped at table size
  always_comb begin
    priority if (prime_count == '0) begin
      want_clamped = CNT_W'(1);
    end else if (CMP_W'(prime_count) > CMP_W'(MAX_PRIMES)) begin
      want_clamped = CNT_W'(MAX_PRIMES);
    end else begin
      want_clamped = CNT_W'(prime_count);
    end
  end

  assign want_met   = (stored >= want);
  assign scan_end   = (sc_addr >= (BIT_AW + 1)'(SCAN_HALF));
  assign scan_issue = cmd.scan_run && !scan_end && !want_met;
  assign scan_wr    = cmd.scan_run && sc_vld && !bit_rdata && !want_met;

  assign stat.clear_last = (clr_addr == BIT_AW'(BIT_DEPTH - 1));
  assign stat.i_done     = (i >= I_W'(ROOT_END));
  assign stat.bit_marked = bit_rdata;
  assign stat.mark_end   = (m >= M_W'(SIEVE_BITS));
  assign stat.scan_done  = !sc_vld && (scan_end || want_met);

  // bit store ports; entry zero (the number 1) is set by the clear
  assign bit_we    = cmd.clear_step || cmd.mark_step;
  assign bit_waddr = cmd.clear_step ? clr_addr : m[BIT_AW:1];
  assign bit_wdata = cmd.clear_step ? (clr_addr == '0) : 1'b1;
  assign bit_raddr = cmd.sv_read ? BIT_AW'(i >> 1) : sc_addr[BIT_AW-1:0];

  // table ports; entry zero holds 2, written during the clear
  assign tbl_we    = cmd.clear_step || scan_wr;
  assign tbl_waddr = cmd.clear_step ? '0 : stored[TBL_AW-1:0];
  assign tbl_wdata = cmd.clear_step ? FIRST_PRIME : sc_val;

  pts_ram #(
    .WIDTH (1),
    .DEPTH (BIT_DEPTH)
  ) u_bits (
    .clk   (clk),
    .we    (bit_we),
    .waddr (bit_waddr),
    .wdata (bit_wdata),
    .raddr (bit_raddr),
    .rdata (bit_rdata)
  );

  pts_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_PRIMES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (TBL_AW'(item.entry_index)),
    .rdata (tbl_rdata)
  );

  assign idx_ext = CMP_W'(item.entry_index);

  always_comb begin
    priority if (!table_built) begin
      rd_status = ST_NOT_BUILT;
    end else if (idx_ext >= CMP_W'(built_count) || idx_ext >= CMP_W'(MAX_PRIMES)) begin
      rd_status = ST_BEYOND;
    end else begin
      rd_status = ST_READ_OK;
    end
  end

  // build counters, no reset needed: build_init, mark_load and scan_init load them
  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      want     <= want_clamped;
      clr_addr <= '0;
      i        <= I_W'(3);
    end else begin
      if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.sv_next) i <= i + I_W'(2);
    end

    if (cmd.mark_load) begin
      m <= M_W'(M_W'(i) * M_W'(i));
    end else if (cmd.mark_step) begin
      m <= m + M_W'({i, 1'b0});
    end

    if (cmd.scan_init) begin
      sc_addr <= '0;
      stored  <= CNT_W'(1);
    end else begin
      if (scan_issue) begin
        sc_addr <= sc_addr + 1'b1;
        sc_val  <= VAL_W'({sc_addr, 1'b1});
      end
      if (scan_wr) stored <= stored + 1'b1;
    end

    r1_status <= rd_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count <= PRIME_COUNT_RST;
      table_built <= 1'b0;
      built_count <= '0;
      sc_vld      <= 1'b0;
      r1_vld      <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (cfg_we) prime_count <= cfg_wdata;
      if (cmd.build_done) begin
        table_built <= 1'b1;
        built_count <= stored;
      end
      sc_vld <= scan_issue;
      r1_vld <= cmd.rd_accept;
      done   <= r1_vld || cmd.build_done;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    priority if (cmd.build_done) begin
      result.status        <= ST_BUILD_DONE;
      result.prime_value   <= '0;
      result.prime_doubled <= '0;
    end else if (r1_status == ST_READ_OK) begin
      result.status        <= r1_status;
      result.prime_value   <= tbl_rdata;
      result.prime_doubled <= {tbl_rdata, 1'b0};
    end else begin
      result.status        <= r1_status;
      result.prime_value   <= '0;
      result.prime_doubled <= '0;
    end
  end

endmodule

// ----- rtl/core/prime_table_sieve_unit.sv -----
// ----------------------------------------------------------------------------
// prime_table_sieve_unit: odd-only sieve of Eratosthenes with a prime table
// Read: done two cycles after the start transfer; one read per cycle.
// Build: holds busy for SIEVE_BITS/2 clear cycles, two per sieve odd below
//   sqrt(SIEVE_BITS)+1, one per marked multiple plus one per sieving prime,
//   about one scan cycle per odd number up to the last stored prime plus
//   three, and one final cycle; done with status 0 as busy falls.
// Reset: table marked not built, count register 4096; the stores are
//   cleared by each build, not by reset. done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module prime_table_sieve_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  pts_pkg::item_t            item,
  output logic                      busy,
  output logic                      done,
  output pts_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [pts_pkg::CFG_W-1:0] cfg_wdata
);
  import pts_pkg::*;

  // Sequencer -> datapath commands and datapath -> sequencer flags.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The sequencer owns the build: clear the bit store (bit for 1 set, table
  // entry 0 = 2), sieve each unmarked odd i by writing i*i, i*i+2i, ...,
  // then scan survivors in ascending order into the table until the
  // requested count is met or the bit store ends. Reads (idle only) run in
  // the datapath's two-stage pipeline (table RAM read, then result register).
  pts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: bit store RAM, prime table RAM, counters and the result
  // register. The result is presented for exactly one cycle; the
  // receiver must take every transfer.
  pts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule

// ----- rtl/core/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker: port-level checks for the prime table sieve unit
// Watches the top level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input pts_pkg::item_t            item,
  input logic                      busy,
  input logic                      done,
  input pts_pkg::result_t          result,
  input logic                      cfg_we,
  input logic [pts_pkg::CFG_W-1:0] cfg_wdata
);
  import pts_pkg::*;

  logic rd_xfer;
  assign rd_xfer = start && !busy && item.op == OP_READ;

  // busy only rises after a build transfer
  a_busy_from_build: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && $past(item.op == OP_BUILD))
    else $error("busy rose without a build transfer");

  // build completion ends busy
  a_build_done: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_BUILD_DONE |-> !busy && $past(busy))
    else $error("build result outside build end");

  // read transfer yields a done with a read status
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    rd_xfer |-> ##2 done && result.status != ST_BUILD_DONE)
    else $error("read result missing");

  // doubled value tracks value; zero unless read ok
  a_value_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> result.prime_doubled == {result.prime_value, 1'b0} &&
             (result.status == ST_READ_OK || result.prime_value == '0))
    else $error("result value fields inconsistent");

endmodule

bind prime_table_sieve_unit pts_checker u_pts_checker (.*);
